[rtl/core/slx_pkg.sv]
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types and constants of the source text lexer: byte codes, token
// kinds, lexer modes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package slx_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT    = 4;
    localparam int FIELD_POS_WIDTH        = 16;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_ASSIGN  = 8'h3D;
    localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    typedef enum logic [3:0] {
        KIND_ASSIGN = 4'd0,
        KIND_LBRACE = 4'd1,
        KIND_RBRACE = 4'd2,
        KIND_LPAREN = 4'd3,
        KIND_RPAREN = 4'd4,
        KIND_STRING = 4'd5,
        KIND_IDENT  = 4'd6,
        KIND_INT    = 4'd7,
        KIND_EOI    = 4'd8
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ID   = 2'd2,
        MODE_INT  = 2'd3
    } lex_mode_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  value_char;
        logic        has_char;
        logic        token_end;
    } token_t;

    typedef struct packed {
        logic                         two;
        token_t                       first;
        token_t                       second;
        logic [FIELD_POS_WIDTH-1:0]   line;
        logic [FIELD_POS_WIDTH-1:0]   column;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } head_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
               ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
    endfunction

endpackage

[rtl/core/slx_byte_if.sv]
// ----------------------------------------------------------------------------
// slx_byte_if
// Source byte channel: one byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

[rtl/core/slx_token_if.sv]
// ----------------------------------------------------------------------------
// slx_token_if
// Token result channel: one result per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface slx_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  value_char;
    logic        has_char;
    logic        token_end;
    logic [15:0] line_number;
    logic [15:0] column_number;

    modport source (
        output valid, output token_kind, output value_char, output has_char,
        output token_end, output line_number, output column_number,
        input ready
    );
    modport sink (
        input valid, input token_kind, input value_char, input has_char,
        input token_end, input line_number, input column_number,
        output ready
    );
endinterface

[rtl/core/slx_front.sv]
// ----------------------------------------------------------------------------
// slx_front
// Classifies each source byte against the lexer mode, updates the mode and
// the saturating line and column counters, and builds a job of up to two
// results for the queue.
// ----------------------------------------------------------------------------
module slx_front
    import slx_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_code,
    output logic       byte_ready,
    input  logic       queue_full,
    output push_t      push
);

    localparam int EXT_WIDTH = POSITION_WIDTH + FIELD_POS_WIDTH;

    typedef enum logic [1:0] {
        POS_KEEP,
        POS_COL_INC,
        POS_NEW_LINE
    } pos_op_t;

    typedef struct packed {
        logic      emit;
        token_t    tok;
        lex_mode_t mode;
        pos_op_t   pos_op;
    } idle_out_t;

    lex_mode_t                 mode_reg, mode_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;
    logic [EXT_WIDTH-1:0]      line_ext, col_ext;
    logic                      accept;
    idle_out_t                 idle_res;
    pos_op_t                   pos_op;
    token_t                    tok_a, tok_b;
    logic                      emit_a, emit_b;

    function automatic token_t make_tok(input token_kind_t k, input logic [7:0] c,
                                        input logic has, input logic fin);
        token_t t;
        t.kind       = k;
        t.value_char = c;
        t.has_char   = has;
        t.token_end  = fin;
        return t;
    endfunction

    function automatic idle_out_t idle_byte(input logic [7:0] c);
        idle_out_t r;
        r.emit   = 1'b0;
        r.tok    = make_tok(KIND_EOI, CHAR_NUL, 1'b0, 1'b1);
        r.mode   = MODE_IDLE;
        r.pos_op = POS_COL_INC;
        priority if (c == CHAR_ASSIGN) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_ASSIGN, c, 1'b1, 1'b1);
        end else if (c == CHAR_LBRACE) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_LBRACE, c, 1'b1, 1'b1);
        end else if (c == CHAR_RBRACE) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_RBRACE, c, 1'b1, 1'b1);
        end else if (c == CHAR_LPAREN) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_LPAREN, c, 1'b1, 1'b1);
        end else if (c == CHAR_RPAREN) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_RPAREN, c, 1'b1, 1'b1);
        end else if (c == CHAR_NUL) begin
            r.emit   = 1'b1;
            r.pos_op = POS_KEEP;
        end else if (c == CHAR_NEWLINE) begin
            r.pos_op = POS_NEW_LINE;
        end else if (c == CHAR_QUOTE) begin
            r.mode = MODE_STR;
        end else if (is_letter(c)) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_IDENT, c, 1'b1, 1'b0);
            r.mode = MODE_ID;
        end else if (is_digit(c)) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_INT, c, 1'b1, 1'b0);
            r.mode = MODE_INT;
        end else begin
            // tab, space and unknown bytes: skip
            r.emit = 1'b0;
        end
        return r;
    endfunction

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;
    assign idle_res   = idle_byte(byte_code);
    assign line_ext   = EXT_WIDTH'(line_reg);
    assign col_ext    = EXT_WIDTH'(col_reg);

    always_comb
    begin
        mode_next = mode_reg;
        pos_op    = POS_KEEP;
        emit_a    = 1'b0;
        emit_b    = 1'b0;
        tok_a     = idle_res.tok;
        tok_b     = idle_res.tok;
        unique case (mode_reg)
            MODE_STR:
            begin
                if (byte_code == CHAR_QUOTE)
                begin
                    emit_a    = 1'b1;
                    tok_a     = make_tok(KIND_STRING, CHAR_NUL, 1'b0, 1'b1);
                    mode_next = MODE_IDLE;
                    pos_op    = POS_COL_INC;
                end
                else if (byte_code == CHAR_NUL)
                begin
                    emit_a    = 1'b1;
                    emit_b    = 1'b1;
                    tok_a     = make_tok(KIND_STRING, CHAR_NUL, 1'b0, 1'b1);
                    tok_b     = make_tok(KIND_EOI, CHAR_NUL, 1'b0, 1'b1);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    emit_a = 1'b1;
                    tok_a  = make_tok(KIND_STRING, byte_code, 1'b1, 1'b0);
                    pos_op = POS_COL_INC;
                end
            end
            MODE_ID, MODE_INT:
            begin
                emit_a = 1'b1;
                if ((mode_reg == MODE_ID) ? is_letter(byte_code) : is_digit(byte_code))
                begin
                    tok_a  = make_tok((mode_reg == MODE_ID) ? KIND_IDENT : KIND_INT,
                                      byte_code, 1'b1, 1'b0);
                    pos_op = POS_COL_INC;
                end
                else
                begin
                    // close the run, then treat the byte as in idle mode
                    tok_a     = make_tok((mode_reg == MODE_ID) ? KIND_IDENT : KIND_INT,
                                         CHAR_NUL, 1'b0, 1'b1);
                    emit_b    = idle_res.emit;
                    tok_b     = idle_res.tok;
                    mode_next = idle_res.mode;
                    pos_op    = idle_res.pos_op;
                end
            end
            MODE_IDLE:
            begin
                emit_a    = idle_res.emit;
                tok_a     = idle_res.tok;
                mode_next = idle_res.mode;
                pos_op    = idle_res.pos_op;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        line_next = line_reg;
        col_next  = col_reg;
        unique case (pos_op)
            POS_COL_INC:
            begin
                if (col_reg != '1)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            POS_NEW_LINE:
            begin
                col_next = '0;
                if (line_reg != '1)
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            default:
            begin
                line_next = line_reg;
            end
        endcase
    end

    always_comb
    begin
        push.valid      = accept && emit_a;
        push.job.two    = emit_b;
        push.job.first  = tok_a;
        push.job.second = tok_b;
        push.job.line   = line_ext[FIELD_POS_WIDTH-1:0];
        push.job.column = col_ext[FIELD_POS_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            line_reg <= '0;
            col_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

[rtl/core/slx_queue.sv]
// ----------------------------------------------------------------------------
// slx_queue
// Short job queue between the front and back: register array with wrapping
// read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module slx_queue
    import slx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    output head_t head,
    input  logic  pop
);

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    job_t                 slot_reg [DEPTH];
    logic [PTR_WIDTH-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == CNT_WIDTH'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/slx_back.sv]
// ----------------------------------------------------------------------------
// slx_back
// Unpacks queued jobs into single result beats and holds them in the output
// register until the sink takes them.
// ----------------------------------------------------------------------------
module slx_back
    import slx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  head_t              head,
    output logic               pop,
    slx_token_if.source        tok_out
);

    logic   out_valid_reg;
    logic   second_reg, second_next;
    token_t tok_reg, tok_next;
    logic [FIELD_POS_WIDTH-1:0] line_reg, col_reg;
    logic   load;

    assign load = head.valid && (!out_valid_reg || tok_out.ready);

    always_comb
    begin
        second_next = second_reg;
        tok_next    = head.job.first;
        pop         = 1'b0;
        if (load)
        begin
            if (second_reg)
            begin
                tok_next    = head.job.second;
                second_next = 1'b0;
                pop         = 1'b1;
            end
            else if (head.job.two)
            begin
                second_next = 1'b1;
            end
            else
            begin
                pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tok_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= tok_next;
            line_reg <= head.job.line;
            col_reg  <= head.job.column;
        end
    end

    assign tok_out.valid         = out_valid_reg;
    assign tok_out.token_kind    = tok_reg.kind;
    assign tok_out.value_char    = tok_reg.value_char;
    assign tok_out.has_char      = tok_reg.has_char;
    assign tok_out.token_end     = tok_reg.token_end;
    assign tok_out.line_number   = line_reg;
    assign tok_out.column_number = col_reg;

endmodule

[rtl/core/source_text_lexer_unit.sv]
// Path: each byte's job is pushed into the queue, then its result beats are
// loaded into the output register. Throughput: one byte per cycle while the
// queue is not full, one result beat per cycle while the sink is ready; a
// byte with two results takes two output beats; the queue absorbs the extra.
// Reset: rst_n clears the lexer mode to idle, both position counters to zero
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
// source_text_lexer_unit
// Source text lexer: front classifier, job queue and result back end.
// ----------------------------------------------------------------------------
module source_text_lexer_unit
    import slx_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    slx_byte_if.sink    in_ch,
    slx_token_if.source out_ch
);

    push_t push;
    head_t head;
    logic  queue_full;
    logic  pop;

    slx_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_ch.valid),
        .byte_code  (in_ch.char_code),
        .byte_ready (in_ch.ready),
        .queue_full (queue_full),
        .push       (push)
    );

    slx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    slx_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .tok_out (out_ch)
    );

endmodule

[tb/sv/tb_source_text_lexer_unit.sv]
// ----------------------------------------------------------------------------
// tb_source_text_lexer_unit
// Self-checking bench for the source text lexer. A directed table walks the
// single-byte tokens, string, identifier and integer runs, run terminators,
// zero bytes and silent bytes. Random token-shaped text follows, then a short
// back-to-back tail of spaces, newlines and tokens. Every result beat is
// checked field by field against the directed table or a local lexer
// predictor, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_source_text_lexer_unit;
    import slx_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_BEAT   = 300;
    localparam int RANDOM_BYTES   = 1640;
    localparam int TAIL_RUN       = 16;
    localparam int MAX_SHOWN      = 10;

    typedef struct {
        token_kind_t kind;
        logic [7:0]  ch;
        logic        has;
        logic        fin;
        logic [15:0] line;
        logic [15:0] col;
    } token_beat_t;

    typedef struct {
        logic [7:0]  c;
        int          n;
        token_beat_t b;
    } lex_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slx_byte_if  byte_ch ();
    slx_token_if tok_ch ();

    source_text_lexer_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_ch),
        .out_ch (tok_ch)
    );

    lex_mode_t   lx_mode = MODE_IDLE;
    logic [15:0] lx_line = '0;
    logic [15:0] lx_col  = '0;

    token_beat_t token_exp_q[$];
    lex_row_t    dir_q[$];

    int bytes_sent    = 0;
    int beats_checked = 0;
    int fail_count    = 0;
    int shown_count   = 0;
    int idle_cycles   = 0;
    int tx_burst      = 0;
    int rx_burst      = 0;
    bit tx_no_idle    = 1'b0;
    bit hold_done     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic token_beat_t mk_beat(token_kind_t k, logic [7:0] ch, logic has,
                                            logic fin, logic [15:0] ln, logic [15:0] cl);
        token_beat_t b;
        b.kind = k;
        b.ch   = ch;
        b.has  = has;
        b.fin  = fin;
        b.line = ln;
        b.col  = cl;
        return b;
    endfunction

    function automatic logic [15:0] pos_inc(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void lex_idle(input logic [7:0] c, input logic [15:0] ln,
                                     input logic [15:0] cl, ref token_beat_t beats[$]);
        token_kind_t kind;
        logic        punct;
        punct = 1'b1;
        case (c)
            CHAR_ASSIGN: kind = KIND_ASSIGN;
            CHAR_LBRACE: kind = KIND_LBRACE;
            CHAR_RBRACE: kind = KIND_RBRACE;
            CHAR_LPAREN: kind = KIND_LPAREN;
            CHAR_RPAREN: kind = KIND_RPAREN;
            default:
            begin
                punct = 1'b0;
                kind  = KIND_EOI;
            end
        endcase
        if (punct)
        begin
            beats.push_back(mk_beat(kind, c, 1'b1, 1'b1, ln, cl));
            lx_col = pos_inc(lx_col);
        end
        else if (c == CHAR_NUL)
        begin
            beats.push_back(mk_beat(KIND_EOI, 8'h00, 1'b0, 1'b1, ln, cl));
        end
        else if (c == CHAR_NEWLINE)
        begin
            lx_line = pos_inc(lx_line);
            lx_col  = '0;
        end
        else if (c == CHAR_QUOTE)
        begin
            lx_mode = MODE_STR;
            lx_col  = pos_inc(lx_col);
        end
        else if (is_alpha(c))
        begin
            lx_mode = MODE_ID;
            beats.push_back(mk_beat(KIND_IDENT, c, 1'b1, 1'b0, ln, cl));
            lx_col = pos_inc(lx_col);
        end
        else if (is_num(c))
        begin
            lx_mode = MODE_INT;
            beats.push_back(mk_beat(KIND_INT, c, 1'b1, 1'b0, ln, cl));
            lx_col = pos_inc(lx_col);
        end
        else
        begin
            lx_col = pos_inc(lx_col);
        end
    endfunction

    function automatic void lex_predict(input logic [7:0] c, ref token_beat_t beats[$]);
        logic [15:0] ln;
        logic [15:0] cl;
        token_kind_t kind;
        logic        stay;
        ln = lx_line;
        cl = lx_col;
        case (lx_mode)
            MODE_STR:
            begin
                if (c == CHAR_QUOTE)
                begin
                    beats.push_back(mk_beat(KIND_STRING, 8'h00, 1'b0, 1'b1, ln, cl));
                    lx_mode = MODE_IDLE;
                    lx_col  = pos_inc(lx_col);
                end
                else if (c == CHAR_NUL)
                begin
                    beats.push_back(mk_beat(KIND_STRING, 8'h00, 1'b0, 1'b1, ln, cl));
                    lx_mode = MODE_IDLE;
                    beats.push_back(mk_beat(KIND_EOI, 8'h00, 1'b0, 1'b1, ln, cl));
                end
                else
                begin
                    beats.push_back(mk_beat(KIND_STRING, c, 1'b1, 1'b0, ln, cl));
                    lx_col = pos_inc(lx_col);
                end
            end
            MODE_ID, MODE_INT:
            begin
                kind = (lx_mode == MODE_ID) ? KIND_IDENT : KIND_INT;
                stay = (lx_mode == MODE_ID) ? is_alpha(c) : is_num(c);
                if (stay)
                begin
                    beats.push_back(mk_beat(kind, c, 1'b1, 1'b0, ln, cl));
                    lx_col = pos_inc(lx_col);
                end
                else
                begin
                    beats.push_back(mk_beat(kind, 8'h00, 1'b0, 1'b1, ln, cl));
                    lx_mode = MODE_IDLE;
                    lex_idle(c, ln, cl, beats);
                end
            end
            default:
                lex_idle(c, ln, cl, beats);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] c);
        int gap;
        if (tx_no_idle)
            gap = 0;
        else if (tx_burst > 0)
        begin
            gap = 0;
            tx_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
                tx_burst = $urandom_range(10, 40);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            byte_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.char_code = c;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    task automatic emit_byte(input logic [7:0] c);
        token_beat_t beats[$];
        send_byte(c);
        lex_predict(c, beats);
        foreach (beats[i])
            token_exp_q.push_back(beats[i]);
    endtask

    // stimulus
    initial
    begin
        token_beat_t no_beat;
        token_beat_t beats[$];
        lex_row_t    row;
        int          sel;
        int          len;
        logic [7:0]  b;

        byte_ch.valid     = 1'b0;
        byte_ch.char_code = 8'h00;
        no_beat = mk_beat(KIND_EOI, 8'h00, 1'b0, 1'b0, 16'd0, 16'd0);

        dir_q.push_back('{CHAR_ASSIGN, 1,
                          mk_beat(KIND_ASSIGN, CHAR_ASSIGN, 1'b1, 1'b1, 16'd0, 16'd0)});
        dir_q.push_back('{CHAR_LBRACE, 1,
                          mk_beat(KIND_LBRACE, CHAR_LBRACE, 1'b1, 1'b1, 16'd0, 16'd1)});
        dir_q.push_back('{CHAR_RBRACE, 1,
                          mk_beat(KIND_RBRACE, CHAR_RBRACE, 1'b1, 1'b1, 16'd0, 16'd2)});
        dir_q.push_back('{CHAR_LPAREN, 1,
                          mk_beat(KIND_LPAREN, CHAR_LPAREN, 1'b1, 1'b1, 16'd0, 16'd3)});
        dir_q.push_back('{CHAR_RPAREN, 1,
                          mk_beat(KIND_RPAREN, CHAR_RPAREN, 1'b1, 1'b1, 16'd0, 16'd4)});
        dir_q.push_back('{8'h20, 0, no_beat});
        dir_q.push_back('{CHAR_TAB, 0, no_beat});
        dir_q.push_back('{8'hFF, 0, no_beat});
        dir_q.push_back('{CHAR_QUOTE, 0, no_beat});
        dir_q.push_back('{CHAR_QUOTE, 1,
                          mk_beat(KIND_STRING, 8'h00, 1'b0, 1'b1, 16'd0, 16'd9)});
        dir_q.push_back('{CHAR_QUOTE, 0, no_beat});
        dir_q.push_back('{CHAR_NEWLINE, -1, no_beat});
        dir_q.push_back('{"x", -1, no_beat});
        dir_q.push_back('{CHAR_NUL, -1, no_beat});
        dir_q.push_back('{CHAR_NEWLINE, 0, no_beat});
        dir_q.push_back('{"A", -1, no_beat});
        dir_q.push_back('{"z", -1, no_beat});
        dir_q.push_back('{"7", -1, no_beat});
        dir_q.push_back('{"0", -1, no_beat});
        dir_q.push_back('{"9", -1, no_beat});
        dir_q.push_back('{CHAR_ASSIGN, -1, no_beat});
        dir_q.push_back('{"Z", -1, no_beat});
        dir_q.push_back('{CHAR_NUL, -1, no_beat});
        dir_q.push_back('{CHAR_NUL, -1, no_beat});
        dir_q.push_back('{"5", -1, no_beat});
        dir_q.push_back('{8'h80, -1, no_beat});
        dir_q.push_back('{"b", -1, no_beat});
        dir_q.push_back('{CHAR_NEWLINE, -1, no_beat});
        dir_q.push_back('{CHAR_QUOTE, -1, no_beat});
        dir_q.push_back('{8'h01, -1, no_beat});
        dir_q.push_back('{CHAR_QUOTE, -1, no_beat});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_q[i])
        begin
            row = dir_q[i];
            send_byte(row.c);
            beats.delete();
            lex_predict(row.c, beats);
            if (row.n < 0)
            begin
                foreach (beats[j])
                    token_exp_q.push_back(beats[j]);
            end
            else if (row.n == 1)
                token_exp_q.push_back(row.b);
        end

        while (bytes_sent < dir_q.size() + RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
            begin
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    b = 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
                    emit_byte(b);
                end
            end
            else if (sel < 40)
            begin
                len = $urandom_range(1, 6);
                repeat (len) emit_byte(8'("0" + $urandom_range(0, 9)));
            end
            else if (sel < 55)
            begin
                emit_byte(CHAR_QUOTE);
                len = $urandom_range(0, 8);
                repeat (len)
                begin
                    do b = 8'($urandom_range(1, 255)); while (b == CHAR_QUOTE);
                    emit_byte(b);
                end
                if ($urandom_range(0, 9) != 0)
                    emit_byte(CHAR_QUOTE);
            end
            else if (sel < 70)
            begin
                case ($urandom_range(0, 4))
                    0: emit_byte(CHAR_ASSIGN);
                    1: emit_byte(CHAR_LBRACE);
                    2: emit_byte(CHAR_RBRACE);
                    3: emit_byte(CHAR_LPAREN);
                    default: emit_byte(CHAR_RPAREN);
                endcase
            end
            else if (sel < 85)
            begin
                case ($urandom_range(0, 2))
                    0: emit_byte(8'h20);
                    1: emit_byte(CHAR_TAB);
                    default: emit_byte(CHAR_NEWLINE);
                endcase
            end
            else if (sel < 88)
                emit_byte(CHAR_NUL);
            else
                emit_byte(8'($urandom_range(0, 255)));
        end

        // back-to-back tail
        emit_byte(CHAR_NEWLINE);
        tx_no_idle = 1'b1;
        repeat (TAIL_RUN) emit_byte(8'h20);
        emit_byte("q");
        emit_byte(8'h20);
        repeat (TAIL_RUN) emit_byte(CHAR_NEWLINE);
        emit_byte(CHAR_ASSIGN);
        emit_byte("7");
        emit_byte(CHAR_NUL);
        tx_no_idle = 1'b0;

        @(negedge clk);
        byte_ch.valid = 1'b0;

        while (token_exp_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("summary: %0d source bytes sent, %0d result beats checked, %0d failures",
                 bytes_sent, beats_checked, fail_count);
        $display("covered: directed tokens, random token text, output stall, gapless tail");
        if (fail_count == 0)
            $display("source_text_lexer_unit test passed");
        else
            $display("source_text_lexer_unit test failed");
        $finish;
    end

    // result sink and checker
    initial
    begin
        token_beat_t exp_b;
        int          gap;

        tok_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && beats_checked >= HOLD_AT_BEAT)
            begin
                hold_done    = 1'b1;
                tok_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (rx_burst > 0)
            begin
                gap = 0;
                rx_burst--;
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0)
                    rx_burst = $urandom_range(10, 40);
            end
            if (gap > 0)
            begin
                tok_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            tok_ch.ready = 1'b1;
            do @(posedge clk); while (!tok_ch.valid);
            beats_checked++;
            if (token_exp_q.size() == 0)
            begin
                fail_count++;
                if (shown_count < MAX_SHOWN)
                begin
                    shown_count++;
                    $display("unexpected beat: kind=%0d ch=%02h has=%0b end=%0b line=%0d col=%0d",
                             tok_ch.token_kind, tok_ch.value_char, tok_ch.has_char,
                             tok_ch.token_end, tok_ch.line_number, tok_ch.column_number);
                end
            end
            else
            begin
                exp_b = token_exp_q.pop_front();
                if (tok_ch.token_kind !== exp_b.kind || tok_ch.value_char !== exp_b.ch ||
                    tok_ch.has_char !== exp_b.has || tok_ch.token_end !== exp_b.fin ||
                    tok_ch.line_number !== exp_b.line || tok_ch.column_number !== exp_b.col)
                begin
                    fail_count++;
                    if (shown_count < MAX_SHOWN)
                    begin
                        shown_count++;
                        $display("mismatch beat %0d: exp kind=%0d ch=%02h has=%0b end=%0b %0d:%0d",
                                 beats_checked, exp_b.kind, exp_b.ch, exp_b.has, exp_b.fin,
                                 exp_b.line, exp_b.col);
                        $display("                got kind=%0d ch=%02h has=%0b end=%0b %0d:%0d",
                                 tok_ch.token_kind, tok_ch.value_char, tok_ch.has_char,
                                 tok_ch.token_end, tok_ch.line_number, tok_ch.column_number);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, token_exp_q.size());
                $display("source_text_lexer_unit test failed");
                $finish;
            end
        end
    end

endmodule

[source_text_lexer_unit.f]
rtl/core/slx_pkg.sv
rtl/core/slx_byte_if.sv
rtl/core/slx_token_if.sv
rtl/core/slx_front.sv
rtl/core/slx_queue.sv
rtl/core/slx_back.sv
rtl/core/source_text_lexer_unit.sv
tb/sv/tb_source_text_lexer_unit.sv
